// ----- hdl/gbdm_pkg.sv -----
package gbdm_pkg;

  localparam int DefaultMaxRows = 64;
  localparam int DefaultMaxCols = 64;

  localparam int DistW = 12;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  localparam int CfgW     = 7;
  localparam int PaddrW   = 3;
  localparam int PdataW   = 32;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_COMPUTE = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QRY,
    ST_SEED,
    ST_POP,
    ST_NB,
    ST_DONE
  } state_e;

endpackage

// ----- hdl/grid_bfs_distance_map_unit.sv -----
// Grid breadth-first distance map. Load items (action 0) write one obstacle
// bit and answer at once; query items (action 2) read one cell and answer
// through the query and done states; items with a coordinate outside the
// grid in use, and the unused action code, answer at once with their status.
// A compute item (action 1) first sweeps the reached map, one entry a cycle
// over 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries (4096 at the default
// size), then walks the grid breadth-first from the goal. For each reachable
// cell the walk makes one frontier queue read and four neighbor reads,
// pipelined against their checks through the separate read and write ports
// of the cell memory. After reset the same sweep runs once over the same
// entries and no item is taken until it ends; register writes are taken at
// any time. Cell address is {row, col}. grid_rows / grid_cols keep the low
// 7 bits written and read them back; 0 acts as 1 and values above the
// maximum act as the maximum. Distances saturate at 4095.
module grid_bfs_distance_map_unit #(
  parameter int MAX_ROWS = gbdm_pkg::DefaultMaxRows,
  parameter int MAX_COLS = gbdm_pkg::DefaultMaxCols
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gbdm_pkg::PaddrW-1:0] paddr,
  input  logic [gbdm_pkg::PdataW-1:0] pwdata,
  output logic [gbdm_pkg::PdataW-1:0] prdata,
  output logic                        pready,
  // item channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [5:0]                  row_i,
  input  logic [5:0]                  col_i,
  input  logic                        blocked_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gbdm_pkg::DistW-1:0]  distance_o,
  output logic                        reachable_o,
  output logic                        status_o
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int Depth = 1 << AW;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int DW    = gbdm_pkg::DistW;
  localparam int QW    = AW + DW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [gbdm_pkg::CfgW-1:0] grid_rows_q, grid_rows_d;
  logic [gbdm_pkg::CfgW-1:0] grid_cols_q, grid_cols_d;
  logic                      cfg_we;
  gbdm_pkg::reg_idx_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = gbdm_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    grid_rows_d = grid_rows_q;
    grid_cols_d = grid_cols_q;
    if (cfg_we) begin
      case (cfg_idx)
        gbdm_pkg::REG_GRID_ROWS: grid_rows_d = pwdata[gbdm_pkg::CfgW-1:0];
        gbdm_pkg::REG_GRID_COLS: grid_cols_d = pwdata[gbdm_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      gbdm_pkg::REG_GRID_ROWS:
        prdata = {{(gbdm_pkg::PdataW-gbdm_pkg::CfgW){1'b0}}, grid_rows_q};
      gbdm_pkg::REG_GRID_COLS:
        prdata = {{(gbdm_pkg::PdataW-gbdm_pkg::CfgW){1'b0}}, grid_cols_q};
      default: prdata = '0;
    endcase
  end

  // Clamp to the usable extent: zero acts as one, oversize acts as maximum.
  logic [RCW-1:0] eff_rows;
  logic [CCW-1:0] eff_cols;

  always_comb begin
    if (grid_rows_q == '0) begin
      eff_rows = RCW'(1);
    end else if (int'(grid_rows_q) > MAX_ROWS) begin
      eff_rows = RCW'(MAX_ROWS);
    end else begin
      eff_rows = RCW'(grid_rows_q);
    end
    if (grid_cols_q == '0) begin
      eff_cols = CCW'(1);
    end else if (int'(grid_cols_q) > MAX_COLS) begin
      eff_cols = CCW'(MAX_COLS);
    end else begin
      eff_cols = CCW'(grid_cols_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: obstacle bits, cell entries {reached, distance}, frontier queue
  // ---------------------------------------------------------------------------
  logic              obs_mem [Depth];
  logic [DW:0]       cell_mem [Depth];
  logic [QW-1:0]     fifo_mem [Depth];

  logic              obs_we, cell_we, fifo_we;
  logic [AW-1:0]     obs_waddr, obs_raddr, cell_waddr, cell_raddr, fifo_waddr, fifo_raddr;
  logic              obs_wdata;
  logic [DW:0]       cell_wdata;
  logic [QW-1:0]     fifo_wdata;
  logic              obs_rdata_q;
  logic [DW:0]       cell_rdata_q;
  logic [QW-1:0]     fifo_rdata_q;

  always_ff @(posedge clk_i) begin
    if (obs_we) begin
      obs_mem[obs_waddr] <= obs_wdata;
    end
    obs_rdata_q <= obs_mem[obs_raddr];
  end

  // one write port and one read port
  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rdata_q <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
    fifo_rdata_q <= fifo_mem[fifo_raddr];
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  gbdm_pkg::state_e state_q, state_d;
  logic             init_q, init_d;        // sweep after reset, no walk
  logic [AW:0]      clr_cnt_q, clr_cnt_d;
  logic [AW:0]      head_q, head_d, tail_q, tail_d;
  logic [2:0]       step_q, step_d;
  logic [AW-1:0]    cur_addr_q, cur_addr_d;
  logic [DW-1:0]    nxt_dist_q, nxt_dist_d;
  logic [AW-1:0]    goal_q, goal_d;
  logic [AW-1:0]    nb_addr_q, nb_addr_d;
  logic             nb_ok_q, nb_ok_d;

  logic             out_valid_q, out_valid_d;
  logic [DW-1:0]    out_dist_q, out_dist_d;
  logic             out_reach_q, out_reach_d;
  logic             out_stat_q, out_stat_d;

  logic             in_xfer, out_free, in_grid;
  logic [AW-1:0]    in_addr;
  gbdm_pkg::action_e act;

  assign act      = gbdm_pkg::action_e'(action_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == gbdm_pkg::ST_IDLE) && out_free;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign in_grid  = (int'(row_i) < int'(eff_rows)) && (int'(col_i) < int'(eff_cols));
  assign in_addr  = {RW'(row_i), CW'(col_i)};

  assign out_valid_o = out_valid_q;
  assign distance_o  = out_dist_q;
  assign reachable_o = out_reach_q;
  assign status_o    = out_stat_q;

  // Popped cell: straight from the queue read on the first step, held after.
  logic [AW-1:0] cur_addr;
  logic [DW-1:0] cur_dist;
  logic [RW-1:0] cur_r;
  logic [CW-1:0] cur_c;

  always_comb begin
    if (step_q == 3'd0) begin
      cur_addr = fifo_rdata_q[QW-1:DW];
      cur_dist = (fifo_rdata_q[DW-1:0] == gbdm_pkg::DistMax) ?
                 gbdm_pkg::DistMax : fifo_rdata_q[DW-1:0] + DW'(1);
    end else begin
      cur_addr = cur_addr_q;
      cur_dist = nxt_dist_q;
    end
    cur_r = cur_addr[AW-1:CW];
    cur_c = cur_addr[CW-1:0];
  end

  // Neighbor of the current step: up, down, left, right.
  logic [AW-1:0] nb_addr;
  logic          nb_ok;

  always_comb begin
    nb_addr = cur_addr;
    nb_ok   = 1'b0;
    case (step_q)
      3'd0: begin
        nb_addr = {cur_r - RW'(1), cur_c};
        nb_ok   = (cur_r != '0);
      end
      3'd1: begin
        nb_addr = {cur_r + RW'(1), cur_c};
        nb_ok   = (int'(cur_r) + 1 < int'(eff_rows));
      end
      3'd2: begin
        nb_addr = {cur_r, cur_c - CW'(1)};
        nb_ok   = (cur_c != '0);
      end
      3'd3: begin
        nb_addr = {cur_r, cur_c + CW'(1)};
        nb_ok   = (int'(cur_c) + 1 < int'(eff_cols));
      end
      default: ;
    endcase
  end

  // visit check for the neighbor read on the previous step
  logic visit;
  assign visit = (state_q == gbdm_pkg::ST_NB) && (step_q != 3'd0) && nb_ok_q &&
                 !cell_rdata_q[DW] && !obs_rdata_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gbdm_pkg::ST_CLEAR: begin
        if (clr_cnt_q == (AW+1)'(Depth - 1)) begin
          state_d = init_q ? gbdm_pkg::ST_IDLE : gbdm_pkg::ST_SEED;
        end
      end
      gbdm_pkg::ST_IDLE: begin
        if (in_xfer && in_grid) begin
          case (act)
            gbdm_pkg::ACT_COMPUTE: state_d = gbdm_pkg::ST_CLEAR;
            gbdm_pkg::ACT_QUERY:   state_d = gbdm_pkg::ST_QRY;
            default: ;
          endcase
        end
      end
      gbdm_pkg::ST_QRY:  state_d = gbdm_pkg::ST_DONE;
      gbdm_pkg::ST_SEED: state_d = gbdm_pkg::ST_POP;
      gbdm_pkg::ST_POP: begin
        state_d = (head_q == tail_q) ? gbdm_pkg::ST_DONE : gbdm_pkg::ST_NB;
      end
      gbdm_pkg::ST_NB: begin
        if (step_q == 3'd4) begin
          state_d = gbdm_pkg::ST_POP;
        end
      end
      gbdm_pkg::ST_DONE: state_d = gbdm_pkg::ST_IDLE;
      default: state_d = gbdm_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    init_d      = init_q;
    clr_cnt_d   = clr_cnt_q;
    head_d      = head_q;
    tail_d      = tail_q;
    step_d      = step_q;
    cur_addr_d  = cur_addr_q;
    nxt_dist_d  = nxt_dist_q;
    goal_d      = goal_q;
    nb_addr_d   = nb_addr_q;
    nb_ok_d     = nb_ok_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_dist_d  = out_dist_q;
    out_reach_d = out_reach_q;
    out_stat_d  = out_stat_q;

    obs_we     = 1'b0;
    obs_waddr  = in_addr;
    obs_wdata  = blocked_i;
    obs_raddr  = nb_addr;
    cell_we    = 1'b0;
    cell_waddr = in_addr;
    cell_raddr = in_addr;
    cell_wdata = '0;
    fifo_we    = 1'b0;
    fifo_waddr = tail_q[AW-1:0];
    fifo_wdata = {goal_q, {DW{1'b0}}};
    fifo_raddr = head_q[AW-1:0];

    case (state_q)
      gbdm_pkg::ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_cnt_q[AW-1:0];
        clr_cnt_d  = clr_cnt_q + (AW+1)'(1);
        if (clr_cnt_q == (AW+1)'(Depth - 1)) begin
          init_d = 1'b0;
        end
      end
      gbdm_pkg::ST_IDLE: begin
        clr_cnt_d = '0;
        goal_d    = in_addr;
        if (in_xfer) begin
          // load, out-of-grid and unused codes answer now
          out_dist_d  = '0;
          out_reach_d = 1'b0;
          out_stat_d  = (act != gbdm_pkg::ACT_NONE) && !in_grid;
          out_valid_d = (act == gbdm_pkg::ACT_LOAD) || (act == gbdm_pkg::ACT_NONE) ||
                        !in_grid;
          obs_we      = (act == gbdm_pkg::ACT_LOAD) && in_grid;
        end
      end
      gbdm_pkg::ST_QRY: cell_raddr = goal_q;  // hold the read of the queried cell
      gbdm_pkg::ST_SEED: begin
        cell_we    = 1'b1;
        cell_waddr = goal_q;
        cell_wdata = {1'b1, {DW{1'b0}}};
        fifo_we    = 1'b1;
        fifo_waddr = '0;
        head_d     = '0;
        tail_d     = (AW+1)'(1);
      end
      gbdm_pkg::ST_POP: begin
        step_d = '0;
        if (head_q != tail_q) begin
          head_d = head_q + (AW+1)'(1);
        end
      end
      gbdm_pkg::ST_NB: begin
        cur_addr_d = cur_addr;
        nxt_dist_d = cur_dist;
        step_d     = step_q + 3'd1;
        nb_addr_d  = nb_addr;
        nb_ok_d    = nb_ok;
        cell_raddr = nb_addr;
        if (visit) begin
          // claim the neighbor and queue it
          cell_we    = 1'b1;
          cell_waddr = nb_addr_q;
          cell_wdata = {1'b1, nxt_dist_q};
          fifo_we    = 1'b1;
          fifo_wdata = {nb_addr_q, nxt_dist_q};
          tail_d     = tail_q + (AW+1)'(1);
        end
      end
      gbdm_pkg::ST_DONE: begin
        out_valid_d = 1'b1;
        out_stat_d  = 1'b0;
        if (cell_rdata_q[DW] && !init_q && (step_q == 3'd7)) begin
          out_dist_d  = cell_rdata_q[DW-1:0];
          out_reach_d = 1'b1;
        end else begin
          out_dist_d  = '0;
          out_reach_d = 1'b0;
        end
      end
      default: ;
    endcase

    // mark query runs so the done state knows to report the read
    if (state_q == gbdm_pkg::ST_IDLE) begin
      step_d = 3'd7;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= gbdm_pkg::CfgW'(64);
      grid_cols_q <= gbdm_pkg::CfgW'(64);
      state_q     <= gbdm_pkg::ST_CLEAR;
      init_q      <= 1'b1;
      clr_cnt_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      grid_rows_q <= grid_rows_d;
      grid_cols_q <= grid_cols_d;
      state_q     <= state_d;
      init_q      <= init_d;
      clr_cnt_q   <= clr_cnt_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_addr_q  <= cur_addr_d;
    nxt_dist_q  <= nxt_dist_d;
    goal_q      <= goal_d;
    nb_addr_q   <= nb_addr_d;
    nb_ok_q     <= nb_ok_d;
    out_dist_q  <= out_dist_d;
    out_reach_q <= out_reach_d;
    out_stat_q  <= out_stat_d;
  end

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Rows = 64;
  localparam int Cols = 64;
  localparam int Cells = Rows * Cols;
  localparam int DistW = gbdm_pkg::DistW;
  localparam int PaddrW = gbdm_pkg::PaddrW;
  localparam int PdataW = gbdm_pkg::PdataW;
  localparam logic [DistW-1:0] DistMax = gbdm_pkg::DistMax;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             reachable;
    logic             status;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // configuration port
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  // item and result channels
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [1:0]       action_i = gbdm_pkg::ACT_NONE;
  logic [5:0]       row_i = '0;
  logic [5:0]       col_i = '0;
  logic             blocked_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [DistW-1:0] distance_o;
  logic             reachable_o;
  logic             status_o;

  grid_bfs_distance_map_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the grid state, updated as each item is accepted.
  logic [6:0]       rows_reg = 7'd64;
  logic [6:0]       cols_reg = 7'd64;
  logic             obs_shadow [Cells];
  logic             obstacle_known [Cells];
  logic [DistW-1:0] step_count [Cells];
  logic             reached_map [Cells];

  answer_t pending_answers [$];
  int      mismatches = 0;
  bit      idle_en = 1'b1;   // random gaps on both sides
  bit      hold_req = 1'b0;  // ask the receiver for one long hold-off

  function automatic int used_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > Rows) return Rows;
    return rows_reg;
  endfunction

  function automatic int used_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > Cols) return Cols;
    return cols_reg;
  endfunction

  // Breadth-first walk from the goal over free cells of the grid in use.
  function automatic void walk_from_goal(int gr, int gc);
    int frontier [$];
    int k, r, c, d, nr, nc, nk;
    int rows, cols;
    rows = used_rows();
    cols = used_cols();
    foreach (reached_map[i]) reached_map[i] = 1'b0;
    k = gr * Cols + gc;
    reached_map[k] = 1'b1;
    step_count[k] = '0;
    frontier = {frontier, k};
    while (frontier.size() > 0) begin
      k = frontier.pop_front();
      r = k / Cols;
      c = k % Cols;
      d = step_count[k] + 1;
      if (d > DistMax) d = DistMax;
      for (int n = 0; n < 4; n++) begin
        nr = r + (n == 0 ? -1 : n == 1 ? 1 : 0);
        nc = c + (n == 2 ? -1 : n == 3 ? 1 : 0);
        if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
        nk = nr * Cols + nc;
        if (reached_map[nk] || obs_shadow[nk]) continue;
        reached_map[nk] = 1'b1;
        step_count[nk] = d[DistW-1:0];
        frontier = {frontier, nk};
      end
    end
  endfunction

  function automatic answer_t predict_answer(gbdm_pkg::action_e act, int r, int c,
                                             logic blk);
    answer_t a;
    int k;
    a = '0;
    if (act == gbdm_pkg::ACT_NONE) return a;
    if (r >= used_rows() || c >= used_cols()) begin
      a.status = 1'b1;
      return a;
    end
    k = r * Cols + c;
    case (act)
      gbdm_pkg::ACT_LOAD: begin
        obs_shadow[k] = blk;
        obstacle_known[k] = 1'b1;
      end
      gbdm_pkg::ACT_COMPUTE: walk_from_goal(r, c);
      default: begin
        if (reached_map[k]) begin
          a.distance = step_count[k];
          a.reachable = 1'b1;
        end
      end
    endcase
    return a;
  endfunction

  // True when every cell of the grid in use holds a loaded obstacle bit.
  function automatic bit grid_loaded();
    for (int r = 0; r < used_rows(); r++)
      for (int c = 0; c < used_cols(); c++)
        if (!obstacle_known[r * Cols + c]) return 1'b0;
    return 1'b1;
  endfunction

  // Offer one item, hold it until the transfer, then log its expected answer.
  task automatic send_item(gbdm_pkg::action_e act, int r, int c, logic blk);
    answer_t a;
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    action_i = act;
    row_i = r[5:0];
    col_i = c[5:0];
    blocked_i = blk;
    do @(posedge clk_i); while (!in_ready_o);
    a = predict_answer(act, r, c, blk);
    pending_answers = {pending_answers, a};
  endtask

  // Drop valid and wait until every expected answer has come back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending_answers.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(gbdm_pkg::reg_idx_e idx, logic [PdataW-1:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = PaddrW'(idx) << 2;
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == gbdm_pkg::REG_GRID_ROWS) rows_reg = value[6:0];
    else cols_reg = value[6:0];
  endtask

  task automatic set_grid(logic [6:0] rows, logic [6:0] cols);
    drain();
    write_reg(gbdm_pkg::REG_GRID_ROWS, rows);
    write_reg(gbdm_pkg::REG_GRID_COLS, cols);
  endtask

  // Load every cell of the grid in use; about a quarter become obstacles.
  task automatic load_grid();
    for (int r = 0; r < used_rows(); r++)
      for (int c = 0; c < used_cols(); c++)
        send_item(gbdm_pkg::ACT_LOAD, r, c, $urandom_range(0, 3) == 0);
  endtask

  // Edges of the fields, the unused action, blocked goal, out-of-grid items.
  task automatic test_directed();
    send_item(gbdm_pkg::ACT_QUERY, 63, 63, 1'b0);
    send_item(gbdm_pkg::ACT_QUERY, 0, 0, 1'b1);
    send_item(gbdm_pkg::ACT_NONE, 63, 63, 1'b1);
    set_grid(7'd0, 7'd0);
    send_item(gbdm_pkg::ACT_LOAD, 0, 0, 1'b1);
    send_item(gbdm_pkg::ACT_COMPUTE, 0, 0, 1'b0);
    send_item(gbdm_pkg::ACT_QUERY, 0, 0, 1'b0);
    send_item(gbdm_pkg::ACT_QUERY, 63, 0, 1'b0);
    send_item(gbdm_pkg::ACT_LOAD, 0, 63, 1'b1);
    send_item(gbdm_pkg::ACT_COMPUTE, 5, 5, 1'b0);
    send_item(gbdm_pkg::ACT_QUERY, 0, 0, 1'b0);
    set_grid(7'd3, 7'd3);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_item(gbdm_pkg::ACT_LOAD, r, c, r == 1 && c < 2);
    send_item(gbdm_pkg::ACT_COMPUTE, 0, 0, 1'b0);
    send_item(gbdm_pkg::ACT_QUERY, 2, 0, 1'b0);
    send_item(gbdm_pkg::ACT_QUERY, 1, 1, 1'b0);
  endtask

  // Thin grids at the register extremes; the goal sits on the far edge and a
  // loaded obstacle next to it bounds the walk.
  task automatic test_register_extremes();
    set_grid(7'd127, 7'd1);
    send_item(gbdm_pkg::ACT_LOAD, 62, 0, 1'b1);
    send_item(gbdm_pkg::ACT_COMPUTE, 63, 0, 1'b0);
    send_item(gbdm_pkg::ACT_QUERY, 63, 0, 1'b0);
    send_item(gbdm_pkg::ACT_QUERY, 62, 0, 1'b0);
    send_item(gbdm_pkg::ACT_QUERY, 0, 1, 1'b0);
    set_grid(7'd1, 7'd127);
    send_item(gbdm_pkg::ACT_LOAD, 0, 62, 1'b1);
    send_item(gbdm_pkg::ACT_COMPUTE, 0, 63, 1'b0);
    send_item(gbdm_pkg::ACT_QUERY, 0, 63, 1'b0);
    send_item(gbdm_pkg::ACT_QUERY, 0, 0, 1'b0);
    send_item(gbdm_pkg::ACT_QUERY, 1, 0, 1'b0);
  endtask

  // Random grids: load the whole grid first, then a random mix.
  task automatic test_random(int phases, int per_phase);
    int sel, r, c;
    gbdm_pkg::action_e act;
    for (int p = 0; p < phases; p++) begin
      set_grid($urandom_range(1, 5), $urandom_range(1, 5));
      load_grid();
      send_item(gbdm_pkg::ACT_COMPUTE, $urandom_range(0, used_rows() - 1),
                $urandom_range(0, used_cols() - 1), 1'b0);
      for (int i = 0; i < per_phase; i++) begin
        sel = $urandom_range(0, 19);
        if (sel < 9) act = gbdm_pkg::ACT_QUERY;
        else if (sel < 13) act = gbdm_pkg::ACT_COMPUTE;
        else if (sel < 19) act = gbdm_pkg::ACT_LOAD;
        else act = gbdm_pkg::ACT_NONE;
        if ($urandom_range(0, 9) == 0) begin
          r = $urandom_range(0, 63);
          c = $urandom_range(0, 63);
        end else begin
          r = $urandom_range(0, used_rows() - 1);
          c = $urandom_range(0, used_cols() - 1);
        end
        send_item(act, r, c, $urandom_range(0, 1));
      end
    end
  endtask

  // Hold the receiver off while queries keep coming, then pause the sender.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++)
      send_item(gbdm_pkg::ACT_QUERY, $urandom_range(0, used_rows() - 1),
                $urandom_range(0, used_cols() - 1), 1'b0);
    drain();
  endtask

  // Result side: ready with random stalls, one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    answer_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result dist=%0d", distance_o);
      end else begin
        want = pending_answers.pop_front();
        if (want.distance !== distance_o || want.reachable !== reachable_o ||
            want.status !== status_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp dist=%0d reach=%0b status=%0b got %0d %0b %0b",
                     want.distance, want.reachable, want.status,
                     distance_o, reachable_o, status_o);
        end
      end
    end
  end

  initial begin
    foreach (obs_shadow[i]) begin
      obs_shadow[i] = 1'b0;
      obstacle_known[i] = 1'b0;
      step_count[i] = '0;
      reached_map[i] = 1'b0;
    end
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_register_extremes();
    test_random(2, 10);
    test_backpressure();
    idle_en = 1'b0;
    test_random(1, 6);
    drain();
    if (mismatches == 0 && pending_answers.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule
